### rtl/core/tsrp_pkg.sv
// Shared types, constants and the log-add table entry function for the
// timestamp-rule token picker. No dependencies.
`default_nettype none
package tsrp_pkg;

	localparam int unsigned VOCAB_MAX_DEF = 65536;
	localparam int unsigned LA_DEPTH_DEF  = 256;

	localparam int unsigned SCORE_W = 20;
	localparam int unsigned TOKEN_W = 16;
	localparam int unsigned MAP_DEPTH = 65536;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [TOKEN_W-1:0]        token_t;

	localparam score_t Q_MIN = 20'sh80000;
	localparam score_t Q_MAX = 20'sh7FFFF;

	typedef enum logic [1:0] {
		ACT_RESET_HIST = 2'd0,
		ACT_APPEND     = 2'd1,
		ACT_MAP_WR     = 2'd2,
		ACT_SCORE      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_TS_BASE    = 2'd0,
		REG_END_TOKEN  = 2'd1,
		REG_INIT_LIMIT = 2'd2,
		REG_CHUNK_CNT  = 2'd3
	} reg_idx_t;

	localparam token_t TS_BASE_RST    = 16'd50364;
	localparam token_t END_TOKEN_RST  = 16'd50257;
	localparam token_t INIT_LIMIT_RST = 16'd50;
	localparam token_t CHUNK_CNT_RST  = 16'd1500;

	typedef struct packed {
		token_t ts_base;
		token_t end_token;
		token_t init_limit;
		token_t chunk_cnt;
	} cfg_t;

	// pass totals handed to the final decision stage
	typedef struct packed {
		logic   t_seen;
		logic   s_seen;
		score_t t_best;
		token_t t_idx;
		score_t t_sum;
		score_t s_best;
		token_t s_idx;
		score_t s_sum;
	} snap_t;

	// shift-subtract quotient, only evaluated while building the table
	function automatic longint unsigned udiv64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(4096 * ln(1 + exp(-x))), x given in Q12; Q30 series
	function automatic logic [15:0] la_entry(input longint unsigned x_q12);
		longint unsigned u, sum, t, g, w, w2, p, acc, one;
		int unsigned n;
		one = 64'd1 << 30;
		u = x_q12 << 14;
		sum = one;
		t = one;
		for (n = 1; n <= 20; n++) begin
			t = udiv64(t * u, 64'(n) << 30);
			if (n[0]) sum = sum - t;
			else sum = sum + t;
		end
		for (n = 0; n < 4; n++) begin
			sum = (sum * sum) >> 30;
		end
		g = sum;
		w = udiv64(g << 30, (one << 1) + g);
		w2 = (w * w) >> 30;
		p = w;
		acc = 0;
		for (n = 1; n <= 41; n += 2) begin
			acc = acc + udiv64(p, 64'(n));
			p = (p * w2) >> 30;
		end
		acc = acc << 1;
		return 16'((acc + (64'd1 << 17)) >> 18);
	endfunction

endpackage
`default_nettype wire

### rtl/core/tsrp_logadd.sv
// Table-based log-add of two Q7.12 values with saturation.
// Depends on tsrp_pkg.
`default_nettype none
module tsrp_logadd #(
	parameter int unsigned LA_DEPTH = tsrp_pkg::LA_DEPTH_DEF
) (
	input  tsrp_pkg::score_t a,
	input  tsrp_pkg::score_t b,
	output tsrp_pkg::score_t r
);
	import tsrp_pkg::*;

	localparam int unsigned IDX_W = $clog2(LA_DEPTH);

	logic [15:0] tab [LA_DEPTH];

	for (genvar k = 0; k < LA_DEPTH; k++) begin : g_tab
		localparam longint unsigned X = (64'(k) * 64'd32768) / LA_DEPTH;
		localparam logic [15:0] V = la_entry(X);
		assign tab[k] = V;
	end

	score_t             hi, lo;
	logic [20:0]        d;
	logic [33:0]        prod, sh;
	logic [15:0]        addend;
	logic signed [20:0] sum;

	always_comb begin
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		d = 21'({hi[19], hi} - {lo[19], lo});
		prod = 34'(d) * 34'(LA_DEPTH);
		sh = prod >> 15;
		addend = (sh < 34'(LA_DEPTH)) ? tab[sh[IDX_W-1:0]] : 16'd0;
		sum = {hi[19], hi} + $signed({5'b0, addend});
		r = (sum > 21'sd524287) ? Q_MAX : sum[19:0];
	end
endmodule
`default_nettype wire

### rtl/core/tsrp_accum.sv
// Per-score stage: masking under the timestamp rules, history update,
// maxima and log-sum accumulation; registers pass totals on the last score.
// Depends on tsrp_pkg and tsrp_logadd.
`default_nettype none
module tsrp_accum #(
	parameter int unsigned VOCAB_MAX = tsrp_pkg::VOCAB_MAX_DEF,
	parameter int unsigned LA_DEPTH  = tsrp_pkg::LA_DEPTH_DEF,
	parameter int unsigned IW        = $clog2(VOCAB_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               s1_valid,
	input  tsrp_pkg::action_t  s1_action,
	input  tsrp_pkg::token_t   s1_token,
	input  tsrp_pkg::score_t   s1_score,
	input  logic               s1_last,
	input  logic [IW-1:0]      s1_index,
	input  logic [1:0]         s1_bits,
	input  tsrp_pkg::cfg_t     cfg,
	output tsrp_pkg::snap_t    snap_s2,
	output logic               snap_valid_s2
);
	import tsrp_pkg::*;

	// sampled history
	logic [1:0] cnt_q;
	logic       last_st_q, prior_q, have_q;
	token_t     last_stamp_q;

	// pass accumulators
	logic   t_seen_q, s_seen_q;
	score_t t_best_q, t_sum_q, s_best_q, s_sum_q;
	token_t t_idx_q, s_idx_q;

	logic        over, first, prior_eff, masked, in_stamp, is_score;
	logic [16:0] i17, base17, lim17, init_top, chunk_top;
	score_t      la_a, la_r;
	snap_t       nx;

	tsrp_logadd #(.LA_DEPTH(LA_DEPTH)) u_la (.a(la_a), .b(s1_score), .r(la_r));

	always_comb begin
		is_score  = s1_valid && (s1_action == ACT_SCORE);
		over      = (s1_index >= IW'(VOCAB_MAX)) || (32'(s1_index) > 32'd65535);
		i17       = 17'(s1_index);
		base17    = {1'b0, cfg.ts_base};
		first     = (cnt_q == 2'd0);
		prior_eff = (cnt_q != 2'd2) || prior_q;
		lim17     = (last_st_q && !prior_eff) ? {1'b0, last_stamp_q}
			: {1'b0, last_stamp_q} + 17'd1;
		init_top  = base17 + {1'b0, cfg.init_limit};
		chunk_top = base17 + {1'b0, cfg.chunk_cnt};
		in_stamp  = i17 >= base17;
		masked = over || s1_bits[1] || (first && s1_bits[0])
			|| (last_st_q && prior_eff && in_stamp)
			|| (last_st_q && !prior_eff && (i17 < {1'b0, cfg.end_token}))
			|| (have_q && in_stamp && (i17 < lim17))
			|| (first && !in_stamp)
			|| (first && (cfg.init_limit != '0) && (i17 > init_top))
			|| (i17 >= chunk_top);

		la_a = in_stamp ? s_sum_q : t_sum_q;

		nx.t_seen = t_seen_q;
		nx.t_best = t_best_q;
		nx.t_idx  = t_idx_q;
		nx.t_sum  = t_sum_q;
		nx.s_seen = s_seen_q;
		nx.s_best = s_best_q;
		nx.s_idx  = s_idx_q;
		nx.s_sum  = s_sum_q;
		if (!masked) begin
			if (in_stamp) begin
				nx.s_seen = 1'b1;
				if (!s_seen_q) begin
					nx.s_best = s1_score;
					nx.s_idx  = i17[15:0];
					nx.s_sum  = s1_score;
				end else begin
					if (s1_score > s_best_q) begin
						nx.s_best = s1_score;
						nx.s_idx  = i17[15:0];
					end
					nx.s_sum = la_r;
				end
			end else begin
				nx.t_seen = 1'b1;
				if (!t_seen_q) begin
					nx.t_best = s1_score;
					nx.t_idx  = i17[15:0];
					nx.t_sum  = s1_score;
				end else begin
					if (s1_score > t_best_q) begin
						nx.t_best = s1_score;
						nx.t_idx  = i17[15:0];
					end
					nx.t_sum = la_r;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			last_st_q    <= 1'b0;
			prior_q      <= 1'b0;
			have_q       <= 1'b0;
			last_stamp_q <= '0;
			t_seen_q     <= 1'b0;
			s_seen_q     <= 1'b0;
			t_best_q     <= Q_MIN;
			s_best_q     <= Q_MIN;
			t_sum_q      <= Q_MIN;
			s_sum_q      <= Q_MIN;
			t_idx_q      <= '0;
			s_idx_q      <= '0;
			snap_valid_s2 <= 1'b0;
		end else if (adv) begin
			snap_valid_s2 <= is_score && s1_last;
			if (s1_valid && (s1_action == ACT_RESET_HIST)) begin
				cnt_q        <= '0;
				last_st_q    <= 1'b0;
				prior_q      <= 1'b0;
				have_q       <= 1'b0;
				last_stamp_q <= '0;
			end
			if (s1_valid && (s1_action == ACT_APPEND)) begin
				prior_q   <= last_st_q;
				last_st_q <= s1_token >= cfg.ts_base;
				if (s1_token >= cfg.ts_base) begin
					last_stamp_q <= s1_token;
					have_q       <= 1'b1;
				end
				if (cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
			end
			if (is_score) begin
				if (s1_last) begin
					t_seen_q <= 1'b0;
					s_seen_q <= 1'b0;
					t_best_q <= Q_MIN;
					s_best_q <= Q_MIN;
					t_sum_q  <= Q_MIN;
					s_sum_q  <= Q_MIN;
					t_idx_q  <= '0;
					s_idx_q  <= '0;
				end else begin
					t_seen_q <= nx.t_seen;
					s_seen_q <= nx.s_seen;
					t_best_q <= nx.t_best;
					s_best_q <= nx.s_best;
					t_sum_q  <= nx.t_sum;
					s_sum_q  <= nx.s_sum;
					t_idx_q  <= nx.t_idx;
					s_idx_q  <= nx.s_idx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_score && s1_last) snap_s2 <= nx;
	end
endmodule
`default_nettype wire

### rtl/core/tsrp_decide.sv
// Final decision: timestamp-mass test, argmax pick and log-probability.
// Depends on tsrp_pkg and tsrp_logadd.
`default_nettype none
module tsrp_decide #(
	parameter int unsigned LA_DEPTH = tsrp_pkg::LA_DEPTH_DEF
) (
	input  tsrp_pkg::snap_t  snap,
	input  tsrp_pkg::token_t end_token,
	output tsrp_pkg::token_t pick,
	output tsrp_pkg::score_t lp,
	output logic             none
);
	import tsrp_pkg::*;

	score_t             total_la, total, best;
	logic signed [20:0] diff;
	logic               take_stamp;

	tsrp_logadd #(.LA_DEPTH(LA_DEPTH)) u_la (.a(snap.t_sum), .b(snap.s_sum), .r(total_la));

	always_comb begin
		none       = !snap.t_seen && !snap.s_seen;
		take_stamp = snap.s_seen && (!snap.t_seen || (snap.s_sum > snap.t_best));
		total      = snap.s_seen ? total_la : snap.t_sum;
		if (take_stamp) begin
			pick = snap.s_idx;
			diff = {snap.s_best[19], snap.s_best} - {snap.s_sum[19], snap.s_sum};
		end else begin
			if (snap.s_seen && (snap.s_best > snap.t_best)) begin
				pick = snap.s_idx;
				best = snap.s_best;
			end else begin
				pick = snap.t_idx;
				best = snap.t_best;
			end
			diff = {best[19], best} - {total[19], total};
		end
		if (!take_stamp && !(snap.s_seen && (snap.s_best > snap.t_best))) best = snap.t_best;
		else best = snap.s_best;
		if (diff > 21'sd0) lp = '0;
		else if (diff < -21'sd524288) lp = Q_MIN;
		else lp = diff[19:0];
		if (none) begin
			pick = '0;
			lp   = '0;
		end else if (pick == end_token) begin
			lp = '0;
		end
	end
endmodule
`default_nettype wire

### rtl/core/timestamp_rule_token_picker.sv
// Timestamp-rule token picker: one item per cycle; a score is registered in
// stage 1 before the accumulators, a decode step's result reaches out_valid
// via the stage 2 snapshot and output registers, and a held result stalls
// in_ready. Reset clears history and pass state, loads register defaults,
// then zeroes the 65536-entry suppression map, one entry a cycle, in_ready low.
// Depends on tsrp_pkg, tsrp_accum, tsrp_decide.
`default_nettype none
module timestamp_rule_token_picker #(
	parameter int unsigned VOCAB_MAX = tsrp_pkg::VOCAB_MAX_DEF,
	parameter int unsigned LA_DEPTH  = tsrp_pkg::LA_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  tsrp_pkg::token_t  token,
	input  logic [1:0]        map_bits,
	input  tsrp_pkg::score_t  score,
	input  logic              last,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output tsrp_pkg::token_t  chosen_token,
	output tsrp_pkg::score_t  logprob,
	output logic              all_masked,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import tsrp_pkg::*;

	localparam int unsigned IW = $clog2(VOCAB_MAX + 1);

	// Whole pipe moves when the output register is free or being drained.
	logic adv, in_xfer;

	// Register file
	cfg_t     cfg_q;
	reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign wr_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ts_base    <= TS_BASE_RST;
			cfg_q.end_token  <= END_TOKEN_RST;
			cfg_q.init_limit <= INIT_LIMIT_RST;
			cfg_q.chunk_cnt  <= CHUNK_CNT_RST;
		end else if (psel && penable && pwrite) begin
			case (wr_idx)
				REG_TS_BASE:    cfg_q.ts_base    <= pwdata[15:0];
				REG_END_TOKEN:  cfg_q.end_token  <= pwdata[15:0];
				REG_INIT_LIMIT: cfg_q.init_limit <= pwdata[15:0];
				REG_CHUNK_CNT:  cfg_q.chunk_cnt  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_TS_BASE:    prdata = {16'd0, cfg_q.ts_base};
			REG_END_TOKEN:  prdata = {16'd0, cfg_q.end_token};
			REG_INIT_LIMIT: prdata = {16'd0, cfg_q.init_limit};
			REG_CHUNK_CNT:  prdata = {16'd0, cfg_q.chunk_cnt};
			default:        prdata = '0;
		endcase
	end

	// Clear sweep of the suppression map after reset.
	logic [16:0] clr_q;
	logic        clr_done;
	assign clr_done = clr_q[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_done) clr_q <= clr_q + 17'd1;
	end

	assign in_ready = adv && clr_done;
	assign in_xfer  = in_valid && in_ready;

	// Score index runs at the front so the map read lines up with the item.
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_xfer && (action_t'(action) == ACT_SCORE)) begin
			if (last) idx_q <= '0;
			else if (idx_q < IW'(VOCAB_MAX)) idx_q <= idx_q + IW'(1);
		end
	end

	// Suppression map: one write port, registered read into stage 1.
	logic [1:0] map_mem [MAP_DEPTH];
	logic [1:0] bits_s1;

	always_ff @(posedge clk) begin
		if (!clr_done) map_mem[clr_q[15:0]] <= 2'b00;
		else if (in_xfer && (action_t'(action) == ACT_MAP_WR)) map_mem[token] <= map_bits;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) bits_s1 <= map_mem[16'(idx_q)];
	end

	// Stage 1 input register
	logic          valid_s1, last_s1;
	action_t       action_s1;
	token_t        token_s1;
	score_t        score_s1;
	logic [IW-1:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (adv) valid_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1 <= action_t'(action);
			token_s1  <= token;
			score_s1  <= score;
			last_s1   <= last;
			idx_s1    <= idx_q;
		end
	end

	// Accumulation; pass totals land in stage 2 on the last score
	snap_t snap_s2;
	logic  valid_s2;

	tsrp_accum #(.VOCAB_MAX(VOCAB_MAX), .LA_DEPTH(LA_DEPTH), .IW(IW)) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.s1_valid      (valid_s1),
		.s1_action     (action_s1),
		.s1_token      (token_s1),
		.s1_score      (score_s1),
		.s1_last       (last_s1),
		.s1_index      (idx_s1),
		.s1_bits       (bits_s1),
		.cfg           (cfg_q),
		.snap_s2       (snap_s2),
		.snap_valid_s2 (valid_s2)
	);

	token_t pick_w;
	score_t lp_w;
	logic   none_w;

	tsrp_decide #(.LA_DEPTH(LA_DEPTH)) u_decide (
		.snap      (snap_s2),
		.end_token (cfg_q.end_token),
		.pick      (pick_w),
		.lp        (lp_w),
		.none      (none_w)
	);

	// Output register
	logic out_valid_q;
	assign adv       = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			chosen_token <= pick_w;
			logprob      <= lp_w;
			all_masked   <= none_w;
		end
	end
endmodule
`default_nettype wire

### rtl/core/tsrp_checker.sv
// Port-level checks for the token picker, bound to the top level.
// Depends on tsrp_pkg and timestamp_rule_token_picker.
`default_nettype none
module tsrp_props (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input tsrp_pkg::token_t chosen_token,
	input tsrp_pkg::score_t logprob,
	input logic             all_masked
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(chosen_token) && $stable(logprob))
		else $error("result changed while stalled");

	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_masked |-> (chosen_token == '0) && (logprob == '0))
		else $error("all-masked result not zero");

	a_lp_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (logprob == '0) || logprob[19])
		else $error("positive log-probability");
endmodule

bind timestamp_rule_token_picker tsrp_props u_chk (.*);
`default_nettype wire
